// ===== src/dht_pkg.sv =====
// Shared types and constants for the double-hashing table.
// Used by dht_rem, double_hash_table and the testbench; no other dependencies.
package dht_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = SLOT_W + 1;
  localparam int CFG_W       = 6;
  localparam int KEY_W       = 31;
  localparam int VAL_W       = 32;
  localparam int CNT_W       = $clog2(KEY_W);
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(17);
  localparam logic [CFG_W-1:0] STEP_RESET = CFG_W'(11);

  localparam logic REG_TABLE_SIZE   = 1'b0;
  localparam logic REG_STEP_MODULUS = 1'b1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_HIT      = 2'd2,
    ST_MISS     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_STEP,
    S_PROBE,
    S_CHECK,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic             operation;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] result_value;
  } out_t;

endpackage

// ===== src/dht_rem.sv =====
// Bit-serial remainder unit: one dividend bit per cycle, MSB first.
// Depends on dht_pkg for widths.
module dht_rem
  import dht_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] dividend,
  input  logic [CNT_W-1:0] len,
  input  logic [CFG_W-1:0] divisor,
  output logic             done,
  output logic [CFG_W-1:0] rem
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [KEY_W-1:0] sh;
  logic [CFG_W:0]   trial;
  logic [CFG_W:0]   reduced;

  always_comb begin
    trial = {rem, sh[KEY_W-1]};
    if (trial >= {1'b0, divisor}) begin
      reduced = trial - {1'b0, divisor};
    end else begin
      reduced = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= dividend;
      cnt <= len;
      rem <= '0;
    end else if (busy) begin
      rem <= reduced[CFG_W-1:0];
      sh  <= sh << 1;
      cnt <= cnt - 1'b1;
    end
  end

endmodule

// ===== src/double_hash_table.sv =====
// Top level of the double-hashing table: APB config, sequencer, slot memory.
// Depends on dht_pkg and dht_rem.
//
// One item is in flight at a time. An item passes through the bit-serial
// remainder units (key mod table_size and key mod step_modulus side by side),
// reduces the step mod table_size, sets up the slot memory read, probes the
// slot memory once per check step, hands the result off (waiting while the
// output register is full and stalled) and goes back to idle. There is at most
// one probe per slot of the effective table size, at most 32 slots.
// The slot valid marks clear at reset; slot contents are kept across resizes.
// A finished result waits in the output register while the next item runs.
module double_hash_table
  import dht_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [CFG_W-1:0] table_size;
  logic [CFG_W-1:0] step_modulus;
  logic [SIZE_W-1:0] n_eff;
  logic [CFG_W-1:0]  r_eff;

  fsm_t state, state_next;
  in_t  item;

  logic [SLOT_W-1:0] pos, pos_next, pos_adv;
  logic [SLOT_W-1:0] step_q;
  logic [SLOT_W-1:0] probe_idx;
  logic [SIZE_W-1:0] pos_sum;
  logic [SIZE_W-1:0] n_last;

  logic [TABLE_DEPTH-1:0] slot_valid;
  logic [KEY_W+VAL_W-1:0] slot_mem [TABLE_DEPTH];
  logic [KEY_W+VAL_W-1:0] rd_data;
  logic [SLOT_W-1:0]      rd_addr;
  logic                   wr_en;

  logic             accept;
  logic             rem_start;
  logic [KEY_W-1:0] rem_dividend;
  logic [CNT_W-1:0] rem_len;
  logic             n_done, r_done;
  logic [CFG_W-1:0] n_rem, r_rem;
  logic [CFG_W-1:0] step_full;

  status_t          res_status, res_status_next;
  logic [VAL_W-1:0] res_value, res_value_next;
  logic             load_pos, load_step, advance, load_out;
  logic             rd_match, rd_occupied;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size   <= SIZE_RESET;
      step_modulus <= STEP_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_TABLE_SIZE:   table_size   <= pwdata[CFG_W-1:0];
        REG_STEP_MODULUS: step_modulus <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        REG_TABLE_SIZE:   prdata = DATA_W'(table_size);
        REG_STEP_MODULUS: prdata = DATA_W'(step_modulus);
        default: ;
      endcase
    end
  end

  always_comb begin
    if (table_size == '0) begin
      n_eff = SIZE_W'(1);
    end else if (SIZE_W'(table_size) > SIZE_W'(TABLE_DEPTH)) begin
      n_eff = SIZE_W'(TABLE_DEPTH);
    end else begin
      n_eff = SIZE_W'(table_size);
    end
    r_eff  = (step_modulus == '0) ? CFG_W'(1) : step_modulus;
    n_last = n_eff - 1'b1;
  end

  // remainder units
  assign accept    = in_valid && !in_stall;
  assign step_full = r_eff - r_rem;

  always_comb begin
    rem_start    = accept;
    rem_dividend = in_data.key;
    rem_len      = CNT_W'(KEY_W - 1);
    if (state == S_DIV && n_done) begin
      rem_start    = 1'b1;
      rem_dividend = {step_full, {(KEY_W-CFG_W){1'b0}}};
      rem_len      = CNT_W'(CFG_W - 1);
    end
  end

  dht_rem u_rem_n (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (rem_dividend),
    .len      (rem_len),
    .divisor  (n_eff),
    .done     (n_done),
    .rem      (n_rem)
  );

  dht_rem u_rem_r (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (in_data.key),
    .len      (CNT_W'(KEY_W - 1)),
    .divisor  (r_eff),
    .done     (r_done),
    .rem      (r_rem)
  );

  // slot memory
  assign rd_occupied = slot_valid[pos];
  assign rd_match    = rd_data[KEY_W+VAL_W-1:VAL_W] == item.key;

  always_comb begin
    pos_sum = SIZE_W'(pos) + SIZE_W'(step_q);
    if (pos_sum >= n_eff) begin
      pos_sum = pos_sum - n_eff;
    end
    pos_adv = pos_sum[SLOT_W-1:0];
  end

  assign rd_addr = (state == S_CHECK) ? pos_adv : pos;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[pos] <= {item.key, item.value};
    end
    rd_data <= slot_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr_en) begin
      slot_valid[pos] <= 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    res_value_next  = res_value;
    load_pos        = 1'b0;
    load_step       = 1'b0;
    advance         = 1'b0;
    load_out        = 1'b0;
    wr_en           = 1'b0;
    pos_next        = pos;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (n_done && r_done) begin
          load_pos   = 1'b1;
          pos_next   = n_rem[SLOT_W-1:0];
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (n_done) begin
          load_step  = 1'b1;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (item.operation == OP_INSERT && !rd_occupied) begin
          wr_en           = 1'b1;
          res_status_next = ST_INSERTED;
          res_value_next  = '0;
          state_next      = S_DONE;
        end else if (item.operation == OP_SEARCH && !rd_occupied) begin
          res_status_next = ST_MISS;
          res_value_next  = '0;
          state_next      = S_DONE;
        end else if (item.operation == OP_SEARCH && rd_match) begin
          res_status_next = ST_HIT;
          res_value_next  = rd_data[VAL_W-1:0];
          state_next      = S_DONE;
        end else if (SIZE_W'(probe_idx) == n_last) begin
          res_status_next = (item.operation == OP_INSERT) ? ST_FULL : ST_MISS;
          res_value_next  = '0;
          state_next      = S_DONE;
        end else begin
          advance  = 1'b1;
          pos_next = pos_adv;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
    if (load_pos) begin
      probe_idx <= '0;
    end else if (advance) begin
      probe_idx <= probe_idx + 1'b1;
    end
    pos <= pos_next;
    if (load_step) begin
      step_q <= n_rem[SLOT_W-1:0];
    end
    res_status <= res_status_next;
    res_value  <= res_value_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.status       <= res_status;
      out_data.result_value <= res_value;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

// ===== test/double_hash_table_test.sv =====
// Self-checking testbench for double_hash_table: inserts and searches are predicted
// against a mirror of the slot table and compared one by one with each result transfer.
// Depends on dht_pkg and the double_hash_table RTL.
module double_hash_table_test;
  import dht_pkg::*;

  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 80;
  localparam int RECENT_KEYS   = 24;
  localparam int PHASE_ITEMS   = 165;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic [CFG_W-1:0]       mirror_size = SIZE_RESET;
  logic [CFG_W-1:0]       mirror_step = STEP_RESET;
  logic [TABLE_DEPTH-1:0] mirror_valid = '0;
  logic [KEY_W-1:0]       mirror_key [TABLE_DEPTH];
  logic [VAL_W-1:0]       mirror_value [TABLE_DEPTH];

  out_t             awaited_outcomes [$];
  out_t             oldest_outcome;
  logic [KEY_W-1:0] recent_keys [$];

  int errors        = 0;
  int quiet_cycles  = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked    = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  double_hash_table uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_t table_outcome(input in_t item);
    int unsigned n;
    int unsigned r;
    int unsigned stride;
    int unsigned slot;
    bit finished;
    out_t res;
    n = (mirror_size == 0) ? 1 : ((mirror_size > TABLE_DEPTH) ? TABLE_DEPTH : mirror_size);
    r = (mirror_step == 0) ? 1 : mirror_step;
    stride = (r - item.key % r) % n;
    slot = item.key % n;
    finished = 1'b0;
    if (item.operation == OP_INSERT) begin
      res.status = ST_FULL;
    end else begin
      res.status = ST_MISS;
    end
    res.result_value = '0;
    for (int i = 0; i < n; i++) begin
      if (!finished) begin
        if (item.operation == OP_INSERT) begin
          if (!mirror_valid[slot]) begin
            mirror_valid[slot] = 1'b1;
            mirror_key[slot] = item.key;
            mirror_value[slot] = item.value;
            res.status = ST_INSERTED;
            finished = 1'b1;
          end
        end else if (!mirror_valid[slot]) begin
          finished = 1'b1;
        end else if (mirror_key[slot] == item.key) begin
          res.status = ST_HIT;
          res.result_value = mirror_value[slot];
          finished = 1'b1;
        end
        slot = (slot + stride) % n;
      end
    end
    return res;
  endfunction

  function automatic in_t random_item(input int search_pct);
    in_t item;
    int pick;
    if ($urandom_range(99) < search_pct) begin
      item.operation = OP_SEARCH;
    end else begin
      item.operation = OP_INSERT;
    end
    pick = $urandom_range(9);
    if (recent_keys.size() != 0 && pick < 5) begin
      item.key = recent_keys[$urandom_range(recent_keys.size() - 1)];
    end else if (pick < 6) begin
      item.key = $urandom_range(1) ? KEY_MAX : '0;
    end else if (pick < 8) begin
      item.key = KEY_W'($urandom_range(200));
    end else begin
      item.key = KEY_W'($urandom());
    end
    item.value = $urandom();
    return item;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < 100) begin
      $display("mismatch on %s: got %h, awaited %h", field, got, want);
    end
    errors++;
  endtask

  task automatic send_item(input in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited_outcomes.push_back(table_outcome(item));
    if (item.operation == OP_INSERT) begin
      recent_keys.push_back(item.key);
      if (recent_keys.size() > RECENT_KEYS) void'(recent_keys.pop_front());
    end
  endtask

  task automatic offer(input logic op, input logic [KEY_W-1:0] key,
                       input logic [VAL_W-1:0] value);
    in_t item;
    item.operation = op;
    item.key = key;
    item.value = value;
    send_item(item);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic reg_index, input logic [CFG_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_index, 2'b00};
    pwdata <= {(DATA_W - CFG_W)'($urandom()), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_index == REG_TABLE_SIZE) begin
      mirror_size = val;
    end else begin
      mirror_step = val;
    end
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] size, input logic [CFG_W-1:0] step);
    settle();
    write_reg(REG_TABLE_SIZE, size);
    write_reg(REG_STEP_MODULUS, step);
  endtask

  task automatic check_reset_defaults();
    offer(OP_INSERT, '0, '0);
    offer(OP_INSERT, KEY_MAX, '1);
    offer(OP_INSERT, 31'd17, 32'h5A5A_A5A5);
    offer(OP_SEARCH, '0, 32'hFFFF_0000);
    offer(OP_SEARCH, KEY_MAX, '1);
    offer(OP_SEARCH, 31'd17, '0);
    offer(OP_SEARCH, 31'd34, '0);
    offer(OP_INSERT, '0, 32'hA5A5_5A5A);
    offer(OP_SEARCH, '0, '0);
  endtask

  task automatic check_size_extremes();
    configure(6'd2, 6'd0);
    offer(OP_INSERT, 31'd5, 32'h1111_2222);
    offer(OP_INSERT, 31'd8, 32'h3333_4444);
    offer(OP_INSERT, 31'd11, 32'h5555_6666);
    offer(OP_SEARCH, 31'd99, '0);
    offer(OP_SEARCH, 31'd5, '0);
    configure(6'd0, 6'd32);
    offer(OP_INSERT, 31'd40, 32'hDEAD_BEEF);
    offer(OP_SEARCH, 31'd40, '0);
    offer(OP_SEARCH, '0, '0);
    configure(6'd63, 6'd63);
    offer(OP_INSERT, KEY_MAX, 32'h0F0F_F0F0);
    offer(OP_SEARCH, KEY_MAX, '0);
    offer(OP_INSERT, 31'd1000, 32'h8000_0001);
    configure(6'd32, 6'd1);
    offer(OP_INSERT, 31'd31, 32'h7FFF_FFFE);
    offer(OP_SEARCH, 31'd31, '0);
  endtask

  task automatic check_backpressure();
    configure(6'd12, 6'd5);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asked++;
    repeat (16) send_item(random_item(50));
    wait_drained();
    repeat (12) send_item(random_item(50));
  endtask

  task automatic run_random_phases();
    int sizes [8];
    int steps [8];
    sizes = '{4, 7, 11, 1, 16, 0, 24, 63};
    steps = '{3, 32, 0, 63, 7, 5, 13, 31};
    for (int p = 0; p < 8; p++) begin
      configure(CFG_W'(sizes[p]), CFG_W'(steps[p]));
      if (p < 3) begin
        send_idle_pct = 21;
        recv_idle_pct = 84;
      end else if (p < 6) begin
        send_idle_pct = 84;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat (PHASE_ITEMS) send_item(random_item(65));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (awaited_outcomes.size() == 0) begin
        report_mismatch("unexpected transfer", 32'(out_data.status), 32'(out_data.result_value));
      end else begin
        oldest_outcome = awaited_outcomes.pop_front();
        if (out_data.status !== oldest_outcome.status) begin
          report_mismatch("status", 32'(out_data.status), 32'(oldest_outcome.status));
        end
        if (out_data.result_value !== oldest_outcome.result_value) begin
          report_mismatch("result_value", out_data.result_value, oldest_outcome.result_value);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_reset_defaults();
    check_size_extremes();
    check_backpressure();
    run_random_phases();
    settle();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
